FILE: sv/ffha_pkg.sv
// ============================================================================
// ffha_pkg
// Types and register indexes shared by the first-fit heap allocator.
// ============================================================================
package ffha_pkg;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FAIL     = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam int REG_HEAP_START  = 0;
    localparam int REG_HEAP_LENGTH = 1;

    typedef struct packed {
        logic        op;
        logic [31:0] request_bytes;
        logic [31:0] release_address;
    } t_req;

    typedef struct packed {
        logic [31:0] payload_address;
        logic [1:0]  status;
        logic [31:0] free_bytes;
    } t_rsp;

endpackage

FILE: sv/first_fit_heap_allocator_unit.sv
// ============================================================================
// first_fit_heap_allocator_unit
// First-fit heap allocator with splitting and neighbor coalescing.
// ============================================================================
// One transaction at a time; busy stays high until the result strobe, which the
// receiver cannot stall. The first-fit scan steps through the entries in S_ARD
// and S_AEVAL, the split shift in S_SHIFT, the merge shift in S_MSHIFT and the free-byte sum in S_SUMACC.
// After reset or a register write the table holds one free block (or none);
// no clearing pass is needed because the entry count bounds every access.
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ffha_pkg::t_req       i_req,
    output logic                 o_valid,
    output ffha_pkg::t_rsp       o_rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [33:0] HDR = 34'(HEADER_BYTES);
    localparam logic [33:0] AMASK = 34'(ALIGN_BYTES - 1);
    localparam logic [33:0] MINREM = 34'd8;
    localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE, S_ARD, S_AEVAL, S_SHIFT, S_SPLIT, S_RRD, S_REVAL,
        S_MRG, S_MSHIFT, S_SUM, S_SUMACC, S_OUT
    } t_state;

    // Table memory: one entry is {offset, payload, free}.
    logic [64:0] mem [MAX_BLOCKS];
    logic [64:0] r_rd;
    logic [IW-1:0] rd_addr;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    logic [64:0] wr_data;

    t_state        r_state, n_state;
    logic [31:0]   r_start, r_len;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_k, n_k;
    logic [33:0]   r_n, n_n;
    logic [31:0]   r_arg, n_arg;
    logic          r_op, n_op;
    logic [64:0]   r_hold, n_hold;   // entry at the scan hit
    logic [64:0]   r_prev, n_prev;   // previous entry during release scan
    logic [31:0]   r_addr, n_addr;
    logic [1:0]    r_st, n_st;
    logic [32:0]   r_sum, n_sum;
    logic          r_mlo, n_mlo;     // merge with lower neighbor pending
    logic [IW-1:0] r_mi, n_mi;       // entry receiving the merge
    logic          r_valid, n_valid;
    t_rsp          r_rsp, n_rsp;
    logic          r_first, n_first;
    logic          r_rebuild;

    // Rebuild of the single initial block.
    logic [33:0] base, adj, len;
    logic        empty;
    always_comb begin
        base = (34'(r_start) + AMASK) & ~AMASK;
        adj  = base - 34'(r_start);
        len  = 34'(r_len) - adj;
        if (base + len > 34'h1_0000_0000) len = 34'h1_0000_0000 - base;
        empty = (34'(r_len) <= adj) || (base >= 34'h1_0000_0000) || (len <= HDR + MINREM);
    end

    wire cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            1'b0:    prdata = r_start;
            default: prdata = r_len;
        endcase
    end

    wire        rd_free = r_rd[0];
    wire [31:0] rd_pay  = r_rd[32:1];
    wire [31:0] rd_off  = r_rd[64:33];
    wire [33:0] rel_key = 34'(rd_off) + HDR;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_i = r_i; n_k = r_k; n_n = r_n;
        n_arg = r_arg; n_op = r_op; n_hold = r_hold; n_prev = r_prev;
        n_addr = r_addr; n_st = r_st; n_sum = r_sum; n_mlo = r_mlo; n_mi = r_mi;
        n_valid = 1'b0; n_rsp = r_rsp; n_first = r_first;
        rd_addr = r_i[IW-1:0];
        wr_en = 1'b0; wr_addr = '0; wr_data = '0;
        if (r_rebuild) begin
            wr_en = 1'b1; wr_addr = '0;
            wr_data = {base[31:0], 32'(len - HDR), 1'b1};
            n_cnt = empty ? '0 : CW'(1);
        end
        case (r_state)
            S_IDLE: begin
                if (start && !r_rebuild) begin
                    n_op = i_req.op; n_i = '0; n_addr = '0; n_mlo = 1'b0;
                    n_first = 1'b1;
                    if (i_req.op == OP_ALLOC) begin
                        n_arg = i_req.request_bytes;
                        n_n = (34'(i_req.request_bytes) + AMASK) & ~AMASK;
                        n_st = ST_FAIL;
                        n_state = (i_req.request_bytes == '0) ? S_SUM : S_ARD;
                    end else begin
                        n_arg = i_req.release_address;
                        n_st = ST_REJECTED;
                        n_state = S_RRD;
                    end
                end
            end
            S_ARD: begin
                n_state = (r_i < r_cnt) ? S_AEVAL : S_SUM;
            end
            S_AEVAL: begin
                if (rd_free && 34'(rd_pay) >= r_n) begin
                    n_hold = r_rd; n_st = ST_DONE;
                    n_addr = 32'(34'(rd_off) + HDR);
                    if (34'(rd_pay) >= r_n + HDR + MINREM && r_cnt < CMAX) begin
                        n_k = r_cnt; n_state = S_SHIFT;
                    end else begin
                        wr_en = 1'b1; wr_addr = r_i[IW-1:0];
                        wr_data = {rd_off, rd_pay, 1'b0};
                        n_state = S_SUM; n_i = '0;
                    end
                end else begin
                    n_i = r_i + 1'b1; rd_addr = n_i[IW-1:0]; n_state = S_ARD;
                end
            end
            S_SHIFT: begin
                // Move entries up one place, top first; read k-1 then write k.
                if (r_k > r_i + 1'b1) begin
                    rd_addr = IW'(r_k - 1'b1);
                    if (!r_first) begin
                        wr_en = 1'b1; wr_addr = r_k[IW-1:0]; wr_data = r_rd;
                        n_k = r_k - 1'b1;
                    end
                    n_first = !r_first;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (r_first) begin
                    wr_en = 1'b1; wr_addr = IW'(r_i + 1'b1);
                    wr_data = {32'(34'(r_hold[64:33]) + HDR + r_n),
                               32'(34'(r_hold[32:1]) - r_n - HDR), 1'b1};
                    n_first = 1'b0;
                end else begin
                    wr_en = 1'b1; wr_addr = r_i[IW-1:0];
                    wr_data = {r_hold[64:33], r_n[31:0], 1'b0};
                    n_cnt = r_cnt + 1'b1; n_i = '0; n_state = S_SUM;
                end
            end
            S_RRD: begin
                n_state = (r_i < r_cnt) ? S_REVAL : S_SUM;
            end
            S_REVAL: begin
                if (rel_key == 34'(r_arg)) begin
                    if (rd_free) begin
                        n_i = '0; n_state = S_SUM;
                    end else begin
                        n_st = ST_DONE;
                        n_hold = {rd_off, rd_pay, 1'b1};
                        n_mlo = (r_i != '0) && r_prev[0];
                        n_k = r_i + 1'b1; rd_addr = IW'(r_i + 1'b1);
                        n_first = 1'b1; n_state = S_MRG;
                    end
                end else begin
                    n_prev = r_rd;
                    n_i = r_i + 1'b1; rd_addr = n_i[IW-1:0]; n_state = S_RRD;
                end
            end
            S_MRG: begin
                // r_rd holds entry i+1 (when present).
                rd_addr = r_k[IW-1:0];
                if (r_first) begin
                    n_first = 1'b0;
                end else begin
                    if (r_k < r_cnt && rd_free) begin
                        n_hold[32:1] = 32'(34'(r_hold[32:1]) + HDR + 34'(rd_pay));
                        n_cnt = r_cnt - 1'b1;
                        n_k = r_i + 1'b1;  // start of removed range
                        n_first = 1'b1;
                        n_state = S_MSHIFT;
                        n_i = r_i;
                    end else begin
                        n_k = r_cnt; n_state = S_MSHIFT; n_first = 1'b1;
                    end
                    if (r_mlo) begin
                        n_hold[64:33] = r_prev[64:33];
                        n_hold[32:1] = 32'(34'(r_prev[32:1]) + HDR + 34'(n_hold[32:1]));
                        n_mi = IW'(r_i - 1'b1);
                    end else begin
                        n_mi = r_i[IW-1:0];
                    end
                end
            end
            S_MSHIFT: begin
                // Remove holes: entries above shift down to fill the range.
                if (r_first) begin
                    wr_en = 1'b1; wr_addr = r_mi; wr_data = r_hold;
                    n_first = 1'b0;
                    // gap: number of removed entries
                    n_n = 34'(r_mlo) + 34'(r_k != r_cnt ? 1'b1 : 1'b0);
                    n_k = CW'(r_mi) + 1'b1;
                    n_cnt = r_cnt - CW'(r_mlo);
                    rd_addr = IW'(CW'(r_mi) + 1'b1 + CW'(n_n));
                    if (n_n == '0) begin
                        n_i = '0; n_state = S_SUM;
                    end
                end else begin
                    if (r_k < r_cnt) begin
                        wr_en = 1'b1; wr_addr = r_k[IW-1:0]; wr_data = r_rd;
                        n_k = r_k + 1'b1;
                        rd_addr = IW'(n_k + CW'(r_n));
                    end else begin
                        n_i = '0; n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                n_sum = '0; n_i = '0; rd_addr = '0; n_state = S_SUMACC;
            end
            S_SUMACC: begin
                if (r_i < r_cnt) begin
                    if (rd_free) n_sum = 33'(r_sum[31:0]) + 33'(rd_pay);
                    n_i = r_i + 1'b1; rd_addr = n_i[IW-1:0];
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_valid = 1'b1;
                n_rsp.payload_address = (r_st == ST_DONE && r_op == OP_ALLOC) ? r_addr : '0;
                n_rsp.status = r_st;
                n_rsp.free_bytes = r_sum[31:0];
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Merge shift reads are registered: reading mi+1+gap+j lands in r_rd next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_start <= '0; r_len <= '0; r_cnt <= '0;
            r_valid <= 1'b0; r_rebuild <= 1'b1;
        end else begin
            r_rebuild <= 1'b0;
            if (cfg_wr) begin
                if (paddr[2] == 1'(REG_HEAP_START)) r_start <= pwdata;
                if (paddr[2] == 1'(REG_HEAP_LENGTH)) r_len <= pwdata;
                r_rebuild <= 1'b1;
            end
            r_state <= n_state; r_cnt <= n_cnt; r_valid <= n_valid;
        end
        r_i <= n_i; r_k <= n_k; r_n <= n_n; r_arg <= n_arg; r_op <= n_op;
        r_hold <= n_hold; r_prev <= n_prev; r_addr <= n_addr; r_st <= n_st;
        r_sum <= n_sum; r_mlo <= n_mlo; r_mi <= n_mi; r_rsp <= n_rsp;
        r_first <= n_first;
    end

    assign busy    = (r_state != S_IDLE) || r_rebuild;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;
endmodule

FILE: sim/first_fit_heap_allocator_unit_tb.sv
// ============================================================================
// first_fit_heap_allocator_unit_tb
// Self-checking testbench for the first-fit heap allocator. A command queue
// holds allocate and release transactions, register writes and drain marks.
// A clocked driver plays them out, and a predictor of the block table works
// out each expected result. A clocked monitor compares every result strobe
// field by field against the oldest expected result.
// ============================================================================
module first_fit_heap_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int  NBLK    = 64;
    localparam int  HDR     = 16;
    localparam int  ALN     = 8;
    localparam int  WD_MAX  = 20000;
    localparam logic [2:0] ADDR_START  = 3'(REG_HEAP_START * 4);
    localparam logic [2:0] ADDR_LENGTH = 3'(REG_HEAP_LENGTH * 4);

    typedef enum logic [1:0] {CMD_ITEM, CMD_CFG, CMD_DRAIN} t_cmd_kind;
    // How a release picks its address when the command is presented.
    typedef enum logic [1:0] {PICK_RAW, PICK_ALLOCATED, PICK_ANY} t_pick;

    typedef struct {
        t_cmd_kind kind;
        t_req      req;
        t_pick     pick;
        int        idle_pct;
        int        reg_idx;
        logic [31:0] reg_val;
    } t_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_valid;
    t_rsp        o_rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    first_fit_heap_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_rsp(o_rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Block table predictor
    // ------------------------------------------------------------------
    logic [31:0] cfg_start, cfg_length;
    logic [31:0] blk_addr [NBLK];
    logic [31:0] blk_size [NBLK];
    logic        blk_free [NBLK];
    int          blk_cnt;

    function automatic longint unsigned round_up8(longint unsigned v);
        return ((v + ALN - 1) / ALN) * ALN;
    endfunction

    function automatic void heap_rebuild();
        longint unsigned base, adj, len;
        base = round_up8(longint'(cfg_start));
        adj = base - cfg_start;
        for (int k = 0; k < NBLK; k++) begin
            blk_addr[k] = '0;
            blk_size[k] = '0;
            blk_free[k] = 1'b0;
        end
        blk_cnt = 0;
        if (longint'(cfg_length) <= adj || base >= 64'h1_0000_0000) return;
        len = cfg_length - adj;
        if (base + len > 64'h1_0000_0000) len = 64'h1_0000_0000 - base;
        if (len <= HDR + 8) return;
        blk_addr[0] = base[31:0];
        blk_size[0] = 32'(len - HDR);
        blk_free[0] = 1'b1;
        blk_cnt = 1;
    endfunction

    function automatic void absorb_next(int i);
        blk_size[i] = blk_size[i] + HDR + blk_size[i+1];
        for (int k = i + 1; k + 1 < blk_cnt; k++) begin
            blk_addr[k] = blk_addr[k+1];
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_cnt--;
        blk_addr[blk_cnt] = '0;
        blk_size[blk_cnt] = '0;
        blk_free[blk_cnt] = 1'b0;
    endfunction

    function automatic t_rsp heap_step(t_req r);
        t_rsp rsp;
        longint unsigned want, sum;
        bit found;
        rsp = '0;
        found = 0;
        if (r.op == OP_ALLOC) begin
            rsp.status = ST_FAIL;
            want = round_up8(longint'(r.request_bytes));
            for (int i = 0; i < blk_cnt && !found && r.request_bytes != 0; i++) begin
                if (blk_free[i] && longint'(blk_size[i]) >= want) begin
                    found = 1;
                    if (longint'(blk_size[i]) >= want + HDR + 8 && blk_cnt < NBLK) begin
                        for (int k = blk_cnt; k > i + 1; k--) begin
                            blk_addr[k] = blk_addr[k-1];
                            blk_size[k] = blk_size[k-1];
                            blk_free[k] = blk_free[k-1];
                        end
                        blk_addr[i+1] = 32'(longint'(blk_addr[i]) + HDR + want);
                        blk_size[i+1] = 32'(longint'(blk_size[i]) - want - HDR);
                        blk_free[i+1] = 1'b1;
                        blk_size[i] = 32'(want);
                        blk_cnt++;
                    end
                    blk_free[i] = 1'b0;
                    rsp.payload_address = blk_addr[i] + HDR;
                    rsp.status = ST_DONE;
                end
            end
        end else begin
            rsp.status = ST_REJECTED;
            for (int i = 0; i < blk_cnt && !found; i++) begin
                if (longint'(blk_addr[i]) + HDR == longint'(r.release_address)) begin
                    found = 1;
                    if (!blk_free[i]) begin
                        rsp.status = ST_DONE;
                        blk_free[i] = 1'b1;
                        if (i + 1 < blk_cnt && blk_free[i+1]) absorb_next(i);
                        if (i > 0 && blk_free[i-1]) absorb_next(i - 1);
                    end
                end
            end
        end
        sum = 0;
        for (int i = 0; i < blk_cnt; i++) if (blk_free[i]) sum += blk_size[i];
        rsp.free_bytes = sum[31:0];
        return rsp;
    endfunction

    function automatic logic [31:0] choose_release(t_pick p, logic [31:0] raw);
        int idx[$];
        for (int i = 0; i < blk_cnt; i++)
            if (p == PICK_ANY || !blk_free[i]) idx.push_back(i);
        if (p == PICK_RAW || idx.size() == 0) return raw;
        return blk_addr[idx[$urandom_range(idx.size() - 1)]] + HDR;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    t_cmd cmd_q[$];
    t_rsp owed_results[$];
    int   n_accepted = 0;
    int   n_returned = 0;
    int   n_errors = 0;

    always @(posedge i_clk) begin
        t_cmd c;
        logic   nx_start, nx_psel, nx_penable;
        t_req   nx_req;
        bit     took;
        nx_start = start;
        nx_req = i_req;
        nx_psel = psel;
        nx_penable = penable;
        took = 0;
        if (i_rst_n) begin
            if (start && !busy) begin
                owed_results.push_back(heap_step(i_req));
                n_accepted++;
                took = 1;
                nx_start = 1'b0;
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_START) cfg_start = pwdata;
                else if (paddr == ADDR_LENGTH) cfg_length = pwdata;
                heap_rebuild();
                nx_psel = 1'b0;
                nx_penable = 1'b0;
            end else if (psel) begin
                nx_penable = 1'b1;
            end
            if (!nx_start && !nx_psel && cmd_q.size() != 0) begin
                c = cmd_q[0];
                case (c.kind)
                    CMD_ITEM: begin
                        if ($urandom_range(99) >= c.idle_pct) begin
                            void'(cmd_q.pop_front());
                            nx_req = c.req;
                            nx_req.release_address =
                                choose_release(c.pick, c.req.release_address);
                            nx_start = 1'b1;
                        end
                    end
                    CMD_DRAIN: begin
                        if (!took && !busy && n_accepted == n_returned)
                            void'(cmd_q.pop_front());
                    end
                    default: begin
                        // Registers change only while no transaction is owed.
                        if (!took && !busy && n_accepted == n_returned) begin
                            void'(cmd_q.pop_front());
                            nx_psel = 1'b1;
                            nx_penable = 1'b0;
                            pwrite <= 1'b1;
                            paddr <= (c.reg_idx == REG_HEAP_START) ? ADDR_START : ADDR_LENGTH;
                            pwdata <= c.reg_val;
                        end
                    end
                endcase
            end
        end
        start <= nx_start;
        i_req <= nx_req;
        psel <= nx_psel;
        penable <= nx_penable;
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            n_returned <= n_returned + 1;
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result, address", o_rsp.payload_address, '0);
            end else begin
                want = owed_results.pop_front();
                if (o_rsp.payload_address !== want.payload_address)
                    report_mismatch("payload_address", o_rsp.payload_address,
                                    want.payload_address);
                if (o_rsp.status !== want.status)
                    report_mismatch("status", 32'(o_rsp.status), 32'(want.status));
                if (o_rsp.free_bytes !== want.free_bytes)
                    report_mismatch("free_bytes", o_rsp.free_bytes, want.free_bytes);
            end
        end
    end

    // Watchdog on cycles with no transaction of any kind.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_MAX) begin
            $display("first_fit_heap_allocator_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_op(logic op, logic [31:0] bytes, logic [31:0] addr, t_pick p, int pct);
        t_cmd c;
        c = '{kind: CMD_ITEM, req: '0, pick: p, idle_pct: pct, reg_idx: 0, reg_val: '0};
        c.req.op = op;
        c.req.request_bytes = bytes;
        c.req.release_address = addr;
        cmd_q.push_back(c);
    endtask

    task automatic add_heap(logic [31:0] base, logic [31:0] len);
        t_cmd c;
        c = '{kind: CMD_CFG, req: '0, pick: PICK_RAW, idle_pct: 0,
              reg_idx: REG_HEAP_START, reg_val: base};
        cmd_q.push_back(c);
        c.reg_idx = REG_HEAP_LENGTH;
        c.reg_val = len;
        cmd_q.push_back(c);
    endtask

    task automatic add_drain();
        t_cmd c;
        c = '{kind: CMD_DRAIN, req: '0, pick: PICK_RAW, idle_pct: 0, reg_idx: 0, reg_val: '0};
        cmd_q.push_back(c);
    endtask

    task automatic add_random(int count, int pct);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 50)      add_op(OP_ALLOC, $urandom_range(1, 256), $urandom, PICK_RAW, pct);
            else if (r < 85) add_op(OP_RELEASE, $urandom, $urandom, PICK_ALLOCATED, pct);
            else if (r < 90) add_op(OP_RELEASE, $urandom, $urandom, PICK_ANY, pct);
            else if (r < 95) add_op(OP_RELEASE, $urandom, $urandom, PICK_RAW, pct);
            else             add_op(OP_ALLOC, $urandom >> $urandom_range(31), $urandom,
                                    PICK_RAW, pct);
            if (n == count / 2) add_drain();
        end
    endtask

    initial begin
        int pcts[3];
        pcts = '{32, 74, 0};
        cfg_start = '0;
        cfg_length = '0;
        heap_rebuild();

        // Empty heap straight out of reset.
        add_op(OP_ALLOC, 32'd8, '0, PICK_RAW, 0);
        add_op(OP_RELEASE, '0, '0, PICK_RAW, 0);
        // Unaligned base; zero, tiny, huge and ordinary requests; bad releases.
        add_heap(32'd3, 32'd1000);
        add_op(OP_ALLOC, 32'd0, '0, PICK_RAW, 0);
        add_op(OP_ALLOC, 32'd1, '0, PICK_RAW, 0);
        add_op(OP_ALLOC, 32'hFFFF_FFFF, '0, PICK_RAW, 0);
        add_op(OP_ALLOC, 32'd100, '0, PICK_RAW, 0);
        add_op(OP_ALLOC, 32'd200, '0, PICK_RAW, 0);
        add_op(OP_RELEASE, '0, '0, PICK_ALLOCATED, 0);
        add_op(OP_RELEASE, '0, '0, PICK_ANY, 0);
        add_op(OP_RELEASE, '0, '0, PICK_RAW, 0);
        add_op(OP_RELEASE, '0, 32'hFFFF_FFFF, PICK_RAW, 0);
        add_op(OP_ALLOC, 32'd2000, '0, PICK_RAW, 0);
        add_op(OP_RELEASE, '0, '0, PICK_ALLOCATED, 0);
        // Whole address space, then a region clipped at the top.
        add_heap(32'd0, 32'hFFFF_FFFF);
        add_op(OP_ALLOC, 32'hFFFF_FFF9, '0, PICK_RAW, 0);
        add_op(OP_ALLOC, 32'hFFFF_FFE8, '0, PICK_RAW, 0);
        add_op(OP_RELEASE, '0, '0, PICK_ALLOCATED, 0);
        add_heap(32'hFFFF_FF00, 32'hFFFF_FFFF);
        add_op(OP_ALLOC, 32'd200, '0, PICK_RAW, 0);
        add_op(OP_RELEASE, '0, '0, PICK_ALLOCATED, 0);
        // Base that aligns past the top, then the smallest non-empty heap.
        add_heap(32'hFFFF_FFFF, 32'd100);
        add_op(OP_ALLOC, 32'd8, '0, PICK_RAW, 0);
        add_heap(32'd0, 32'd25);
        add_op(OP_ALLOC, 32'd9, '0, PICK_RAW, 0);
        add_op(OP_ALLOC, 32'd8, '0, PICK_RAW, 0);
        add_op(OP_RELEASE, '0, 32'd16, PICK_RAW, 0);

        // Random phases; small heaps fill the table, one near the top of memory.
        for (int ph = 0; ph < 3; ph++) begin
            add_heap($urandom, $urandom_range(24, 6000));
            add_random(240, pcts[ph]);
            add_heap(ph == 1 ? 32'hFFFF_E000 + $urandom_range(63) : $urandom_range(0, 4096),
                     $urandom_range(1500, 9000));
            add_random(240, pcts[ph]);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (cmd_q.size() != 0 || start || psel || n_accepted != n_returned);
        repeat (250) @(posedge i_clk);
        if (n_errors == 0 && owed_results.size() == 0)
            $display("first_fit_heap_allocator_unit verification clean");
        else
            $display("first_fit_heap_allocator_unit verification failed");
        $finish;
    end
endmodule
